FILE: rtl/line_scan_camera_sequencer_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the line-scan camera sequencer.
// ----------------------------------------------------------------------------
`ifndef LINE_SCAN_CAMERA_SEQUENCER_DEFINES_SVH
`define LINE_SCAN_CAMERA_SEQUENCER_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define LSCS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define LSCS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/lscs_pkg.sv
// ----------------------------------------------------------------------------
// lscs_pkg
// Shared types and constants of the line-scan camera sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lscs_pkg;

  // Default number of pixels in one line.
  localparam int PIXELS_DEF = 128;

  // Field widths.
  localparam int OP_W     = 2;
  localparam int ADC_W    = 16;
  localparam int ADDR_IN_W = 7;
  localparam int PIX_W    = 12;

  // Number of distinct read addresses the request can carry.
  localparam int ADDR_SPAN = 2 ** ADDR_IN_W;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd1;
  localparam logic [OP_W-1:0] OP_START  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  // Input request.
  typedef struct packed {
    logic [OP_W-1:0]      operation;
    logic [ADC_W-1:0]     adc_raw;
    logic [ADDR_IN_W-1:0] pixel_addr;
  } lscs_in_t;

  // Result of one request.
  typedef struct packed {
    logic             clk_level;
    logic             si_level;
    logic [PIX_W-1:0] pixel_value;
    logic             line_done;
  } lscs_out_t;

  // Control carried from the state-update stage to the output register.
  typedef struct packed {
    logic clk_level;
    logic si_level;
    logic line_done;
    logic hit;
  } lscs_stage_t;

endpackage

FILE: rtl/lscs_ram.sv
// ----------------------------------------------------------------------------
// lscs_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lscs_ram #(
  parameter int WIDTH = 12,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port; read data holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/line_scan_camera_sequencer.sv
// ----------------------------------------------------------------------------
// line_scan_camera_sequencer
// Drives CLK and SI of a linear light sensor and captures one line of pixels.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the item channel (valid/ready) as lscs_in_t: a clock
//   tick, an ADC sample, a start of line capture, or a pixel read. Every
//   request yields exactly one lscs_out_t on the result channel with the CLK
//   and SI pin levels after the request, the read pixel (zero for other
//   requests) and a line-done flag on the tick that ends a capture.
//   The result is registered: the request passes a stage register, then the
//   output register. One request is accepted per cycle while the result
//   channel does not stall; the line-store RAM takes one write (tick) or one
//   registered read (read request) per cycle.
//   While the receiver stalls, the output register and one stage behind it
//   fill, then item_ready drops until the result is taken.
//   Reset (synchronous, active high) sets the phase counter to -2, CLK high,
//   SI low, the sequence armed and the sample zero. The line store is not
//   swept: a fill count marks the pixels written since reset and unwritten
//   pixels read as zero, so the block is ready in the cycle after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "line_scan_camera_sequencer_defines.svh"

module line_scan_camera_sequencer
  import lscs_pkg::*;
#(
  parameter int PIXELS = PIXELS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  output logic      item_ready,
  input  lscs_in_t  item,
  output logic      result_valid,
  input  logic      result_ready,
  output lscs_out_t result
);

  localparam int AW     = $clog2(PIXELS);
  localparam int CNT_W  = $clog2(2 * PIXELS + 1) + 1;
  localparam int FILL_W = $clog2(PIXELS + 1);

  localparam logic signed [CNT_W-1:0] CNT_RESET = -CNT_W'(2);
  localparam logic signed [CNT_W-1:0] CNT_M1    = -CNT_W'(1);
  localparam logic signed [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam logic signed [CNT_W-1:0] CNT_TWO   = CNT_W'(2);
  localparam logic signed [CNT_W-1:0] CNT_END   = CNT_W'(2 * PIXELS);

  // Sequencer state.
  logic signed [CNT_W-1:0] phase_count, phase_count_next;
  logic                    clock_level, clock_level_next;
  logic                    si_out, si_out_next;
  logic                    armed, armed_next;
  logic [PIX_W-1:0]        latest_sample;
  logic [FILL_W-1:0]       fill;

  // Pipeline registers.
  logic        s1_valid;
  lscs_stage_t s1;
  lscs_stage_t s1_next;

  logic             accept;
  logic             s1_move;
  logic             done_next;
  logic             we;
  logic [AW-1:0]    waddr;
  logic [AW-1:0]    raddr;
  logic             re;
  logic [PIX_W-1:0] rdata;
  logic             tick_clk;

  // Read address reduced modulo the line length through a constant table.
  logic [AW-1:0] mod_tab [ADDR_SPAN];
  for (genvar g = 0; g < ADDR_SPAN; g++) begin : g_mod
    assign mod_tab[g] = AW'(g % PIXELS);
  end

  assign raddr = mod_tab[item.pixel_addr];

  // Handshake: the stage advances when the output register is free or drains.
  assign s1_move    = s1_valid && (!result_valid || result_ready);
  assign item_ready = !s1_valid || s1_move;
  assign accept     = item_valid && item_ready;
  assign re         = accept && (item.operation == OP_READ);

  // Tick and request decode.
  always_comb begin
    phase_count_next = phase_count;
    clock_level_next = clock_level;
    si_out_next      = si_out;
    armed_next       = armed;
    done_next        = 1'b0;
    we               = 1'b0;
    waddr            = phase_count[AW:1];
    tick_clk         = ~clock_level;
    unique case (item.operation)
      OP_TICK: begin
        if (armed) begin
          if (phase_count >= CNT_TWO && phase_count < CNT_END) begin
            clock_level_next = tick_clk;
            we               = ~tick_clk;
            phase_count_next = phase_count + CNT_ONE;
          end else if (phase_count < CNT_TWO) begin
            clock_level_next = tick_clk;
            if (phase_count == CNT_M1) begin
              si_out_next = 1'b1;
            end else if (phase_count == CNT_ONE) begin
              si_out_next = 1'b0;
              we          = 1'b1;
              waddr       = '0;
            end
            phase_count_next = phase_count + CNT_ONE;
          end else begin
            clock_level_next = 1'b0;
            phase_count_next = CNT_RESET;
            armed_next       = 1'b0;
            done_next        = 1'b1;
          end
        end
      end
      OP_START: begin
        armed_next = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    s1_next.clk_level = clock_level_next;
    s1_next.si_level  = si_out_next;
    s1_next.line_done = done_next;
    s1_next.hit       = (item.operation == OP_READ) && (FILL_W'(raddr) < fill);
  end

  // Sequencer state update on each accepted request.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_count   <= CNT_RESET;
      clock_level   <= 1'b1;
      si_out        <= 1'b0;
      armed         <= 1'b1;
      latest_sample <= '0;
      fill          <= '0;
    end else if (accept) begin
      phase_count <= phase_count_next;
      clock_level <= clock_level_next;
      si_out      <= si_out_next;
      armed       <= armed_next;
      if (item.operation == OP_SAMPLE) begin
        latest_sample <= item.adc_raw[ADC_W-1:ADC_W-PIX_W];
      end
      // Pixels are written in ascending order, so one count tracks them.
      if (we && FILL_W'(waddr) >= fill) begin
        fill <= FILL_W'(waddr) + FILL_W'(1);
      end
    end
  end

  // Line store.
  lscs_ram #(
    .WIDTH(PIX_W),
    .DEPTH(PIXELS)
  ) u_ram (
    .clk  (clk),
    .we   (accept && we),
    .waddr(waddr),
    .wdata(latest_sample),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // Stage one valid flag and control payload.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_move) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      result.clk_level   <= s1.clk_level;
      result.si_level    <= s1.si_level;
      result.line_done   <= s1.line_done;
      result.pixel_value <= s1.hit ? rdata : '0;
    end
  end

  // Checks on the sequencer and the pipeline.
  `LSCS_ASSERT_NOW(a_done_pins_low, result_valid && result.line_done,
    !result.clk_level && !result.si_level, "line done with a pin still high")
  `LSCS_ASSERT_NOW(a_fill_bound, 1'b1, fill <= FILL_W'(PIXELS),
    "fill count beyond line length")
  `LSCS_ASSERT_NOW(a_disarmed_count, !armed, phase_count == CNT_RESET,
    "disarmed with the phase counter away from its start")
  `LSCS_ASSERT_NOW(a_si_window, si_out,
    phase_count == '0 || phase_count == CNT_ONE, "SI high outside its window")
  `LSCS_ASSERT_NEXT(a_stage_holds, s1_valid && !s1_move && !accept,
    s1_valid && $stable(s1), "stage one changed while stalled")

endmodule
